### rtl/core/ale_pkg.sv
// ale_pkg: shared types and constants of the ansi line editor
// holds the command format between the parser and the line engine,
// the result codes and the terminal byte codes; depends on nothing
package ale_pkg;

   // result action codes
   localparam logic [2:0] ACT_ECHO      = 3'd0;
   localparam logic [2:0] ACT_RIGHT     = 3'd1;
   localparam logic [2:0] ACT_LEFT      = 3'd2;
   localparam logic [2:0] ACT_ERASE     = 3'd3;
   localparam logic [2:0] ACT_BACKSPACE = 3'd4;
   localparam logic [2:0] ACT_LINE_CHAR = 3'd5;
   localparam logic [2:0] ACT_SUBMIT    = 3'd6;

   // command codes from the parser to the line engine
   localparam logic [2:0] OP_PRINT     = 3'd0;
   localparam logic [2:0] OP_BACKSPACE = 3'd1;
   localparam logic [2:0] OP_DELETE    = 3'd2;
   localparam logic [2:0] OP_ENTER     = 3'd3;
   localparam logic [2:0] OP_RIGHT     = 3'd4;
   localparam logic [2:0] OP_LEFT      = 3'd5;

   // terminal byte codes
   localparam logic [7:0] CH_BS       = 8'h08;
   localparam logic [7:0] CH_CR       = 8'h0D;
   localparam logic [7:0] CH_CAN      = 8'h18;
   localparam logic [7:0] CH_ESC      = 8'h1B;
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_ZERO     = 8'h30;
   localparam logic [7:0] CH_NINE     = 8'h39;
   localparam logic [7:0] CH_SEMI     = 8'h3B;
   localparam logic [7:0] CH_RIGHT    = 8'h43;
   localparam logic [7:0] CH_LEFT     = 8'h44;
   localparam logic [7:0] CH_SS3      = 8'h4F;
   localparam logic [7:0] CH_CSI      = 8'h5B;
   localparam logic [7:0] CH_TILDE    = 8'h7E;
   localparam logic [7:0] CH_DEL      = 8'h7F;

   localparam logic [7:0] PARAM_MAX     = 8'd255;
   localparam logic [7:0] PARAM_DEFAULT = 8'd1;
   localparam logic [7:0] PARAM_DELETE  = 8'd3;

   // command queue
   localparam int CMDQ_DEPTH = 4;
   localparam int CMDQ_AW    = 2;

   typedef struct packed {
      logic [2:0] op;
      logic [7:0] arg;
   } cmd_type;

   typedef struct packed {
      logic [2:0] action;
      logic [6:0] value;
      logic       last;
   } rsp_type;

endpackage

### rtl/core/ale_front.sv
// ale_front: escape sequence parser of the ansi line editor
// classifies each accepted byte into an editing command for the line engine
// depends on ale_pkg
module ale_front import ale_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       byte_valid,
   input  logic [7:0] byte_data,
   output logic       cmd_push,
   output cmd_type    cmd
);

   localparam logic [1:0] ESC_GROUND = 2'd0;
   localparam logic [1:0] ESC_SEEN   = 2'd1;
   localparam logic [1:0] ESC_CSI    = 2'd2;
   localparam logic [1:0] ESC_SS3    = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic [7:0]  param_ff, param_in;
   logic        absent_ff, absent_in;
   logic [3:0]  digit;
   logic [11:0] accum;
   logic [7:0]  param_eff;

   assign digit     = 4'(byte_data - CH_ZERO);
   // param * 10 + digit
   assign accum     = {1'b0, param_ff, 3'b000} + {3'b000, param_ff, 1'b0} + {8'h00, digit};
   assign param_eff = absent_ff ? PARAM_DEFAULT : param_ff;

   always_comb begin
      state_in  = state_ff;
      param_in  = param_ff;
      absent_in = absent_ff;
      cmd_push  = 1'b0;
      cmd.op    = OP_PRINT;
      cmd.arg   = byte_data;
      if (byte_valid) begin
         if (byte_data == CH_CAN) begin
            state_in = ESC_GROUND;
         end else begin
            unique case (state_ff)
               ESC_GROUND: begin
                  priority if (byte_data == CH_ESC) begin
                     state_in = ESC_SEEN;
                  end else if (byte_data == CH_BS || byte_data == CH_DEL) begin
                     cmd_push = 1'b1;
                     cmd.op   = OP_BACKSPACE;
                  end else if (byte_data == CH_CR) begin
                     cmd_push = 1'b1;
                     cmd.op   = OP_ENTER;
                  end else if (byte_data >= CH_SPACE && byte_data < CH_DEL) begin
                     cmd_push = 1'b1;
                     cmd.op   = OP_PRINT;
                  end else begin
                     cmd_push = 1'b0;
                  end
               end
               ESC_SEEN: begin
                  priority if (byte_data == CH_CSI) begin
                     state_in  = ESC_CSI;
                     param_in  = 8'd0;
                     absent_in = 1'b1;
                  end else if (byte_data == CH_SS3) begin
                     state_in = ESC_SS3;
                  end else begin
                     // lone escape deletes at the cursor
                     state_in = ESC_GROUND;
                     cmd_push = 1'b1;
                     cmd.op   = OP_DELETE;
                  end
               end
               ESC_CSI: begin
                  priority if (byte_data >= CH_ZERO && byte_data <= CH_NINE) begin
                     absent_in = 1'b0;
                     if (absent_ff) begin
                        param_in = {4'd0, digit};
                     end else if (accum > 12'(PARAM_MAX)) begin
                        param_in = PARAM_MAX;
                     end else begin
                        param_in = accum[7:0];
                     end
                  end else if (byte_data == CH_SEMI) begin
                     state_in = ESC_CSI;
                  end else begin
                     state_in = ESC_GROUND;
                     cmd.arg  = param_eff;
                     priority if (byte_data == CH_RIGHT) begin
                        cmd_push = 1'b1;
                        cmd.op   = OP_RIGHT;
                     end else if (byte_data == CH_LEFT) begin
                        cmd_push = 1'b1;
                        cmd.op   = OP_LEFT;
                     end else if (byte_data == CH_TILDE && param_eff == PARAM_DELETE) begin
                        cmd_push = 1'b1;
                        cmd.op   = OP_DELETE;
                     end else begin
                        cmd_push = 1'b0;
                     end
                  end
               end
               ESC_SS3: begin
                  state_in = ESC_GROUND;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ESC_GROUND;
         param_ff  <= 8'd0;
         absent_ff <= 1'b1;
      end else begin
         state_ff  <= state_in;
         param_ff  <= param_in;
         absent_ff <= absent_in;
      end
   end

endmodule

### rtl/core/ale_cmdq.sv
// ale_cmdq: short command queue between the parser and the line engine
// depends on ale_pkg
module ale_cmdq import ale_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_en,
   input  cmd_type wr_data,
   output logic    q_full,
   input  logic    rd_en,
   output cmd_type rd_data,
   output logic    q_valid
);

   cmd_type              slot_ff [CMDQ_DEPTH];
   logic [CMDQ_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_AW:0]     count_ff, count_in;
   logic                 do_wr, do_rd;

   assign q_full  = (count_ff == (CMDQ_AW+1)'(CMDQ_DEPTH));
   assign q_valid = (count_ff != '0);
   assign rd_data = slot_ff[rd_ptr_ff];
   assign do_wr   = wr_en && !q_full;
   assign do_rd   = rd_en && q_valid;

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### rtl/core/ale_back.sv
// ale_back: line engine of the ansi line editor
// owns the line store, cursor and length, runs commands and drives the result register
// depends on ale_pkg
module ale_back import ale_pkg::*; #(
   parameter int LINE_BUFFER_SIZE = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   input  cmd_type cmd,
   output logic    cmd_pop,
   input  logic    rsp_pop,
   output logic    rsp_valid,
   output rsp_type rsp
);

   localparam int AW    = $clog2(LINE_BUFFER_SIZE);
   localparam int DEPTH = LINE_BUFFER_SIZE - 1;
   localparam logic [AW-1:0] LAST_COL = AW'(LINE_BUFFER_SIZE - 1);

   localparam logic [1:0] B_IDLE   = 2'd0;
   localparam logic [1:0] B_SHIFT  = 2'd1;
   localparam logic [1:0] B_LINE   = 2'd2;
   localparam logic [1:0] B_SUBMIT = 2'd3;

   logic [6:0]    store [DEPTH];
   logic [6:0]    rd_ff;

   logic [1:0]    state_ff, state_in;
   logic [AW-1:0] len_ff, len_in;
   logic [AW-1:0] cur_ff, cur_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic          out_valid_ff, out_valid_in;
   rsp_type       out_ff, out_in;

   logic          we, re, out_free;
   logic [AW-1:0] waddr, raddr;
   logic [6:0]    wdata;
   logic [AW-1:0] cur_inc, cur_dec, len_dec, idx_nxt, idx_nxt2, mv_count;
   logic [7:0]    room, mv_count8;

   assign out_free = !out_valid_ff || rsp_pop;
   assign cur_inc  = cur_ff + 1'b1;
   assign cur_dec  = cur_ff - 1'b1;
   assign len_dec  = (len_ff == '0) ? '0 : len_ff - 1'b1;
   assign idx_nxt  = idx_ff + 1'b1;
   assign idx_nxt2 = idx_ff + AW'(2);

   // cursor never passes the line end, so the room never borrows
   always_comb begin
      if (cmd.op == OP_RIGHT) begin
         room = 8'(AW'(len_ff - cur_ff));
      end else begin
         room = 8'(cur_ff);
      end
      mv_count8 = (cmd.arg < room) ? cmd.arg : room;
      mv_count  = AW'(mv_count8);
   end

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      cur_in       = cur_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_in       = out_ff;
      cmd_pop      = 1'b0;
      we           = 1'b0;
      waddr        = cur_ff;
      wdata        = cmd.arg[6:0];
      re           = 1'b0;
      raddr        = cur_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd.op)
                  OP_PRINT: begin
                     if (cur_ff >= LAST_COL) begin
                        cmd_pop = 1'b1;
                     end else if (out_free) begin
                        cmd_pop      = 1'b1;
                        out_valid_in = 1'b1;
                        out_in       = '{action: ACT_ECHO, value: cmd.arg[6:0], last: 1'b1};
                        we           = 1'b1;
                        cur_in       = cur_inc;
                        if (cur_inc > len_ff) begin
                           len_in = cur_inc;
                        end
                     end
                  end
                  OP_BACKSPACE: begin
                     if (cur_ff == '0) begin
                        cmd_pop = 1'b1;
                     end else if (out_free) begin
                        cmd_pop      = 1'b1;
                        out_valid_in = 1'b1;
                        out_in       = '{action: ACT_BACKSPACE, value: 7'd0, last: 1'b1};
                        cur_in       = cur_dec;
                        len_in       = len_dec;
                        if (cur_dec < len_dec) begin
                           // close the gap starting at the new cursor
                           re       = 1'b1;
                           raddr    = cur_ff;
                           idx_in   = cur_dec;
                           state_in = B_SHIFT;
                        end
                     end
                  end
                  OP_DELETE: begin
                     if (cur_ff >= len_ff) begin
                        cmd_pop = 1'b1;
                     end else if (out_free) begin
                        cmd_pop      = 1'b1;
                        out_valid_in = 1'b1;
                        out_in       = '{action: ACT_ERASE, value: 7'd0, last: 1'b1};
                        len_in       = len_dec;
                        if (cur_ff < len_dec) begin
                           re       = 1'b1;
                           raddr    = cur_inc;
                           idx_in   = cur_ff;
                           state_in = B_SHIFT;
                        end
                     end
                  end
                  OP_RIGHT, OP_LEFT: begin
                     if (mv_count == '0) begin
                        cmd_pop = 1'b1;
                     end else if (out_free) begin
                        cmd_pop      = 1'b1;
                        out_valid_in = 1'b1;
                        out_in.value = 7'(mv_count);
                        out_in.last  = 1'b1;
                        if (cmd.op == OP_RIGHT) begin
                           out_in.action = ACT_RIGHT;
                           cur_in        = cur_ff + mv_count;
                        end else begin
                           out_in.action = ACT_LEFT;
                           cur_in        = cur_ff - mv_count;
                        end
                     end
                  end
                  OP_ENTER: begin
                     cmd_pop = 1'b1;
                     if (len_ff == '0) begin
                        state_in = B_SUBMIT;
                     end else begin
                        re       = 1'b1;
                        raddr    = '0;
                        idx_in   = '0;
                        state_in = B_LINE;
                     end
                  end
                  default: begin
                     cmd_pop = 1'b1;
                  end
               endcase
            end
         end
         B_SHIFT: begin
            we    = 1'b1;
            waddr = idx_ff;
            wdata = rd_ff;
            if (idx_nxt < len_ff) begin
               re     = 1'b1;
               raddr  = idx_nxt2;
               idx_in = idx_nxt;
            end else begin
               state_in = B_IDLE;
            end
         end
         B_LINE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_in       = '{action: ACT_LINE_CHAR, value: rd_ff, last: 1'b0};
               if (idx_nxt < len_ff) begin
                  re     = 1'b1;
                  raddr  = idx_nxt;
                  idx_in = idx_nxt;
               end else begin
                  state_in = B_SUBMIT;
               end
            end
         end
         B_SUBMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_in       = '{action: ACT_SUBMIT, value: 7'(len_ff), last: 1'b1};
               len_in       = '0;
               cur_in       = '0;
               state_in     = B_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         store[waddr] <= wdata;
      end
      if (re) begin
         rd_ff <= store[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         len_ff       <= '0;
         cur_ff       <= '0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         cur_ff       <= cur_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;

endmodule

### rtl/core/ansi_line_editor_top.sv
// ansi_line_editor_top: terminal line editor with escape sequence decoding
// instantiates ale_front, ale_cmdq and ale_back; depends on ale_pkg
//
// usage
//   input: one terminal byte per transfer on req_in_byte, taken when push is
//   high and full is low. the parser classifies each byte in the cycle it is
//   taken and drops a command into a four-entry queue; full rises only when
//   that queue is full.
//   results: queue-like; while empty is low the oldest result sits on rsp_action,
//   rsp_value and rsp_last, and pop takes it. rsp_last marks the final result
//   of one byte; bytes with no effect give no result.
//   pace: printing and moves leave the engine idle for the next command, and
//   empty edits are dropped even while a result waits. a delete or backspace
//   walks the line store, moving each character right of the cursor (up to 62)
//   one place left, and takes no new command until the walk ends; enter sends
//   the line, one stored character per cycle while the result register is free.
//   stalls: while a result waits and pop is low, the result register holds it and
//   the engine waits to give another; the queue keeps taking bytes until it fills.
//   reset: synchronous, clears parser, cursor, length and both queues; the
//   line store is not cleared, only written entries are ever read.
module ansi_line_editor_top import ale_pkg::*; #(
   parameter int LINE_BUFFER_SIZE = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [7:0] req_in_byte,
   output logic       empty,
   input  logic       pop,
   output logic [2:0] rsp_action,
   output logic [6:0] rsp_value,
   output logic       rsp_last
);

   logic    byte_take;
   logic    cmd_push, q_full, q_valid, cmd_pop, rsp_valid;
   cmd_type cmd_front, cmd_head;
   rsp_type rsp;

   assign byte_take = push && !q_full;

   ale_front u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (byte_take),
      .byte_data  (req_in_byte),
      .cmd_push   (cmd_push),
      .cmd        (cmd_front)
   );

   ale_cmdq u_cmdq (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (cmd_push),
      .wr_data (cmd_front),
      .q_full  (q_full),
      .rd_en   (cmd_pop),
      .rd_data (cmd_head),
      .q_valid (q_valid)
   );

   ale_back #(
      .LINE_BUFFER_SIZE (LINE_BUFFER_SIZE)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_valid),
      .cmd       (cmd_head),
      .cmd_pop   (cmd_pop),
      .rsp_pop   (pop),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   assign full       = q_full;
   assign empty      = !rsp_valid;
   assign rsp_action = rsp.action;
   assign rsp_value  = rsp.value;
   assign rsp_last   = rsp.last;

endmodule

### rtl/core/ale_checker.sv
// ale_checker: port-level assertions for the ansi line editor
// bound to ansi_line_editor_top; depends on ale_pkg
module ale_checker import ale_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       full,
   input logic       empty,
   input logic       pop,
   input logic [2:0] rsp_action,
   input logic [6:0] rsp_value,
   input logic       rsp_last
);

   // both queues come out of reset drained
   a_reset_drained: assert property (@(posedge clock)
      $past(reset) |-> (empty && !full))
      else $error("queues not drained after reset");

   // a stalled result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_action) && $stable(rsp_value)
                            && $stable(rsp_last)))
      else $error("stalled result changed");

   a_action_range: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_action <= ACT_SUBMIT))
      else $error("undefined action code");

   // line characters are never marked last; the submit marker of the same byte follows them
   a_line_char_not_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_action == ACT_LINE_CHAR) |-> !rsp_last)
      else $error("line character marked last");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_action != ACT_LINE_CHAR) |-> rsp_last)
      else $error("single result not marked last");

endmodule

bind ansi_line_editor_top ale_checker u_ale_checker (
   .clock       (clock),
   .reset       (reset),
   .full        (full),
   .empty       (empty),
   .pop         (pop),
   .rsp_action  (rsp_action),
   .rsp_value   (rsp_value),
   .rsp_last    (rsp_last)
);
